@@ rtl/htok_pkg.sv @@
package htok_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_HEADERS = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  // Field tags carried with each character
  typedef enum logic [2:0] {
    TAG_METHOD  = 3'd0,
    TAG_URL     = 3'd1,
    TAG_VERSION = 3'd2,
    TAG_HNAME   = 3'd3,
    TAG_HVALUE  = 3'd4
  } tag_e;

  // Parse status codes
  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  localparam int unsigned LenW  = 16;
  localparam int unsigned CharW = 7;

  localparam logic [LenW-1:0] MaxLenReset = 16'd8192;

  // Characters of interest
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] CaseBit  = 8'h20;

  // Parser state carried from one byte to the next
  typedef struct packed {
    phase_e          phase;
    logic [LenW-1:0] byte_count;
    logic            line_has_text;
    logic            colon_seen;
  } state_t;

  // One result request
  typedef struct packed {
    logic             char_valid;
    tag_e             field_tag;
    logic [CharW-1:0] out_char;
    logic             field_end;
    status_e          parse_status;
  } result_t;

endpackage

@@ rtl/http_request_head_tokenizer_core.sv @@
// HTTP request head tokenizer. Takes one raw byte of a request head per
// request on the slave stream and gives one result request per byte on the
// master stream: the character with its field tag in tuser (0 method, 1 URL,
// 2 version, 3 header name, 4 header value), tlast when the byte closes a
// field or header line, and the parse status (parsing, head complete, error).
// Header lines are lowercased with spaces and carriage returns dropped.
// Completion and error stick until reset. One byte is taken every cycle while
// the result side keeps up; a stalled result holds the input register and so
// stops the input after one more byte. A byte in the input register is parsed
// into the result register once the result side is free, and its result is
// then presented from there. The whole parse step is combinational between
// the two registers, since each byte's step needs the state left by the byte
// before it. The user must write the length limit through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
module http_request_head_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_message_length
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] char_valid, [7:1] out_char,
                                      // [9:8] parse_status, [15:10] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] field_tag
  output logic        m_axis_tlast    // field_end
);
  import htok_pkg::*;

  logic [LenW-1:0] max_len_q;
  state_t          state_q, state_d;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  result_t         result_q, result_d;
  logic            out_free;
  logic            step_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step_fire;

  // Length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  htok_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .max_len_i   (max_len_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_METHOD, byte_count: '0, line_has_text: 1'b0,
                   colon_seen: 1'b0};
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, result_q.parse_status, result_q.out_char,
                          result_q.char_valid};
  assign m_axis_tuser  = result_q.field_tag;
  assign m_axis_tlast  = result_q.field_end;

endmodule

@@ rtl/htok_step.sv @@
module htok_step (
  input  htok_pkg::state_t         state_i,
  input  logic [7:0]               data_byte_i,
  input  logic [htok_pkg::LenW-1:0] max_len_i,
  output htok_pkg::state_t         state_o,
  output htok_pkg::result_t        result_o
);
  import htok_pkg::*;

  logic [LenW:0] count_inc;
  logic          over_limit;
  logic [7:0]    lower_c;
  tag_e          hdr_tag;

  assign count_inc  = {1'b0, state_i.byte_count} + {{LenW{1'b0}}, 1'b1};
  assign over_limit = count_inc > {1'b0, max_len_i};
  assign hdr_tag    = state_i.colon_seen ? TAG_HVALUE : TAG_HNAME;

  // Lowercase for header lines
  always_comb begin
    lower_c = data_byte_i;
    if (data_byte_i inside {[ChUpperA:ChUpperZ]}) begin
      lower_c = data_byte_i | CaseBit;
    end
  end

  // One parse step
  always_comb begin
    state_o  = state_i;
    result_o = '{char_valid: 1'b0, field_tag: TAG_METHOD, out_char: '0,
                 field_end: 1'b0, parse_status: ST_PARSING};

    case (state_i.phase)
      PH_DONE: begin
        result_o.parse_status = ST_DONE;
      end
      PH_METHOD, PH_URL, PH_VERSION, PH_HEADERS: begin
        if (data_byte_i[7] || over_limit) begin
          state_o.phase         = PH_ERROR;
          result_o.parse_status = ST_ERROR;
        end else begin
          state_o.byte_count = count_inc[LenW-1:0];
          case (state_i.phase)
            PH_METHOD, PH_URL: begin
              result_o.field_tag = (state_i.phase == PH_METHOD) ? TAG_METHOD : TAG_URL;
              if (data_byte_i == ChSpace) begin
                state_o.phase      = (state_i.phase == PH_METHOD) ? PH_URL : PH_VERSION;
                result_o.field_end = 1'b1;
              end else begin
                result_o.char_valid = 1'b1;
                result_o.out_char   = data_byte_i[CharW-1:0];
              end
            end
            PH_VERSION: begin
              result_o.field_tag = TAG_VERSION;
              if (data_byte_i == ChCr) begin
                // dropped
              end else if (data_byte_i == ChLf) begin
                state_o.phase         = PH_HEADERS;
                state_o.line_has_text = 1'b0;
                state_o.colon_seen    = 1'b0;
                result_o.field_end    = 1'b1;
              end else if (data_byte_i == ChSpace) begin
                state_o.phase         = PH_ERROR;
                result_o.field_tag    = TAG_METHOD;
                result_o.parse_status = ST_ERROR;
              end else begin
                result_o.char_valid = 1'b1;
                result_o.out_char   = data_byte_i[CharW-1:0];
              end
            end
            default: begin
              // header lines
              result_o.field_tag = hdr_tag;
              if (data_byte_i == ChCr || data_byte_i == ChSpace) begin
                // dropped
              end else if (data_byte_i == ChLf) begin
                if (!state_i.line_has_text) begin
                  state_o.phase         = PH_DONE;
                  result_o.field_tag    = TAG_HNAME;
                  result_o.parse_status = ST_DONE;
                end else if (!state_i.colon_seen) begin
                  state_o.phase         = PH_ERROR;
                  result_o.field_tag    = TAG_METHOD;
                  result_o.parse_status = ST_ERROR;
                end else begin
                  state_o.line_has_text = 1'b0;
                  state_o.colon_seen    = 1'b0;
                  result_o.field_tag    = TAG_HVALUE;
                  result_o.field_end    = 1'b1;
                end
              end else begin
                state_o.line_has_text = 1'b1;
                if (data_byte_i == ChColon && !state_i.colon_seen) begin
                  state_o.colon_seen = 1'b1;
                  result_o.field_tag = TAG_HNAME;
                  result_o.field_end = 1'b1;
                end else begin
                  result_o.char_valid = 1'b1;
                  result_o.out_char   = lower_c[CharW-1:0];
                end
              end
            end
          endcase
        end
      end
      default: begin
        // error phase, and unused codes fold into it
        state_o.phase         = PH_ERROR;
        result_o.parse_status = ST_ERROR;
      end
    endcase
  end

endmodule
